### rtl/rx_ring_buffer_line_reader_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the receive ring buffer line reader
// Clocked implication checks, reset disables them.
// ---------------------------------------------------------------------------
`ifndef RX_RING_BUFFER_LINE_READER_ASSERT_SVH
`define RX_RING_BUFFER_LINE_READER_ASSERT_SVH

// same-cycle implication
`define RXRB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rxrb assertion failed");

// next-cycle implication
`define RXRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rxrb assertion failed");

`endif

### rtl/rxrb_pkg.sv
// ---------------------------------------------------------------------------
// rxrb_pkg
// Shared types and codes of the receive ring buffer line reader.
// ---------------------------------------------------------------------------
package rxrb_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int COUNT_W       = 6;   // width of available / read_count
    localparam int MAXLEN_W      = 7;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;
    localparam logic [1:0] MODE_LINE  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [7:0]          rx_byte;
        logic [MAXLEN_W-1:0] max_length;
        logic [7:0]          delimiter;
    } request_t;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               has_data;
        logic               last;
        logic [1:0]         status;
        logic [COUNT_W-1:0] available;
        logic [COUNT_W-1:0] read_count;
    } result_t;

endpackage

### rtl/rxrb_stream_if.sv
// ---------------------------------------------------------------------------
// rxrb_stream_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface rxrb_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/rxrb_ring_mem.sv
// ---------------------------------------------------------------------------
// rxrb_ring_mem
// Byte ring storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module rxrb_ring_mem #(
    parameter int DEPTH = rxrb_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/rxrb_ctrl.sv
// ---------------------------------------------------------------------------
// rxrb_ctrl
// Request sequencer: pointers, delimiter scan and byte emission over the ring.
// ---------------------------------------------------------------------------
`include "rx_ring_buffer_line_reader_assert.svh"

module rxrb_ctrl #(
    parameter int DEPTH = rxrb_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  rxrb_pkg::request_t       req_data,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [7:0]               mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    input  logic [7:0]               mem_rdata,
    input  logic                     out_free,
    output logic                     out_load,
    output rxrb_pkg::result_t        out_res
);
    import rxrb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W+1)'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RESP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_EXT)
        begin
            s = s - DEPTH_EXT;
        end
        return s[PTR_W-1:0];
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [PTR_W-1:0]    avail_reg, avail_next;
    logic [PTR_W-1:0]    count_reg, count_next;
    logic [PTR_W-1:0]    iss_idx_reg, iss_idx_next;
    logic [PTR_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [PTR_W-1:0]    ld_idx_reg, ld_idx_next;
    logic                rdv_reg, rdv_next;
    logic                line_reg, line_next;
    logic [1:0]          status_reg, status_next;
    logic [MAXLEN_W-1:0] max_reg, max_next;
    logic [7:0]          delim_reg, delim_next;

    logic             accept;
    logic [PTR_W-1:0] pending;
    logic             load_byte;
    logic             issue;
    logic             last_byte;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign pending   = (wp_reg >= rp_reg) ? (wp_reg - rp_reg)
                     : PTR_W'(({1'b0, wp_reg} + DEPTH_EXT) - {1'b0, rp_reg});

    assign load_byte = (state_reg == S_EMIT) && rdv_reg && out_free;
    assign last_byte = (ld_idx_reg == count_reg - PTR_W'(1));

    always_comb
    begin
        case (state_reg)
            S_SCAN:  issue = (iss_idx_reg < avail_reg);
            S_EMIT:  issue = (iss_idx_reg < count_reg) && (!rdv_reg || load_byte);
            default: issue = 1'b0;
        endcase
    end

    assign mem_re    = issue;
    assign mem_raddr = wrap_add(rp_reg, iss_idx_reg);
    assign mem_we    = accept && (req_data.mode == MODE_PUSH);
    assign mem_waddr = wp_reg;
    assign mem_wdata = req_data.rx_byte;

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        avail_next   = avail_reg;
        count_next   = count_reg;
        iss_idx_next = issue ? iss_idx_reg + PTR_W'(1) : iss_idx_reg;
        rd_idx_next  = issue ? iss_idx_reg : rd_idx_reg;
        ld_idx_next  = ld_idx_reg;
        rdv_next     = issue ? 1'b1 : (load_byte ? 1'b0 : rdv_reg);
        line_next    = line_reg;
        status_next  = status_reg;
        max_next     = max_reg;
        delim_next   = delim_reg;
        out_load     = 1'b0;
        out_res      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    avail_next   = pending;
                    max_next     = req_data.max_length;
                    delim_next   = req_data.delimiter;
                    iss_idx_next = '0;
                    ld_idx_next  = '0;
                    rdv_next     = 1'b0;
                    case (req_data.mode)
                        MODE_PUSH:
                        begin
                            wp_next = wrap_add(wp_reg, PTR_W'(1));
                        end
                        MODE_QUERY:
                        begin
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                        MODE_DRAIN:
                        begin
                            line_next = 1'b0;
                            if (pending == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else if (MAXLEN_W'(pending) > req_data.max_length)
                            begin
                                status_next = ST_TOO_LONG;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                count_next = pending;
                                state_next = S_EMIT;
                            end
                        end
                        MODE_LINE:
                        begin
                            line_next = 1'b1;
                            if (pending == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    out_res.last       = 1'b1;
                    out_res.status     = status_reg;
                    out_res.available  = COUNT_W'(avail_reg);
                    state_next         = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (rdv_reg)
                begin
                    if (mem_rdata == delim_reg)
                    begin
                        rdv_next     = 1'b0;
                        iss_idx_next = '0;
                        ld_idx_next  = '0;
                        if (rd_idx_reg == '0)
                        begin
                            // delimiter at the head: consume it alone
                            rp_next     = wrap_add(rp_reg, PTR_W'(1));
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                        else if (MAXLEN_W'(rd_idx_reg) > max_reg)
                        begin
                            status_next = ST_TOO_LONG;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            count_next = rd_idx_reg;
                            state_next = S_EMIT;
                        end
                    end
                    else if (rd_idx_reg == avail_reg - PTR_W'(1))
                    begin
                        rdv_next    = 1'b0;
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                end
            end

            S_EMIT:
            begin
                if (load_byte)
                begin
                    out_load           = 1'b1;
                    out_res.data_byte  = mem_rdata;
                    out_res.has_data   = 1'b1;
                    out_res.last       = last_byte;
                    out_res.status     = ST_OK;
                    out_res.available  = COUNT_W'(avail_reg);
                    out_res.read_count = COUNT_W'(count_reg);
                    ld_idx_next        = ld_idx_reg + PTR_W'(1);
                    if (last_byte)
                    begin
                        // line mode also consumes the delimiter
                        rp_next    = wrap_add(rp_reg, count_reg + PTR_W'(line_reg));
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            rdv_reg     <= 1'b0;
            iss_idx_reg <= '0;
            ld_idx_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            rdv_reg     <= rdv_next;
            iss_idx_reg <= iss_idx_next;
            ld_idx_reg  <= ld_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avail_reg  <= avail_next;
        count_reg  <= count_next;
        rd_idx_reg <= rd_idx_next;
        line_reg   <= line_next;
        status_reg <= status_next;
        max_reg    <= max_next;
        delim_reg  <= delim_next;
    end

    `RXRB_ASSERT_NEXT(a_wp_stable_busy, clk, rst_n, state_reg != S_IDLE, $stable(wp_reg))
    `RXRB_ASSERT_IMPL(a_no_read_idle, clk, rst_n, state_reg == S_IDLE, !rdv_reg)
    `RXRB_ASSERT_IMPL(a_emit_in_range, clk, rst_n, load_byte, ld_idx_reg < count_reg)
    `RXRB_ASSERT_IMPL(a_scan_in_range, clk, rst_n, (state_reg == S_SCAN) && rdv_reg,
                      rd_idx_reg < avail_reg)
endmodule

### rtl/rx_ring_buffer_line_reader.sv
// ---------------------------------------------------------------------------
// rx_ring_buffer_line_reader
// Receive byte ring with query, drain and read-until-delimiter requests.
// ---------------------------------------------------------------------------
// Usage:
//   req (sink) takes one request per transaction: push a byte, query the
//   pending count, drain all pending bytes, or read a line up to a delimiter.
//   rsp (source) returns result transactions; last marks the final one of
//   each request. A push returns nothing.
// Timing:
//   Pushes are taken one per cycle. Any other request holds req.ready low
//   until its last result sits in the output register.
//   Query, empty and drain too_long results go through S_RESP into the
//   output register. Drain: bytes pass through the read register at one
//   per cycle while the output register is free, set by the single read
//   port of the ring memory. Line read: the scan reads one entry per cycle,
//   then bytes are read out again at one per cycle while the output is free.
// Reset: pointers clear, the ring is empty; ring contents are not cleared
//   and no clearing pass runs.
// Stall: a result waits in the output register while rsp.ready is low;
//   the next memory read is already held in the read register behind it.
// ---------------------------------------------------------------------------
module rx_ring_buffer_line_reader #(
    parameter int DEPTH = rxrb_pkg::DEPTH_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    rxrb_stream_if.sink   req,
    rxrb_stream_if.source rsp
);
    import rxrb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;

    logic             out_free;
    logic             out_load;
    result_t          out_res;

    // output register: one result transaction pending toward rsp
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg;

    rxrb_ring_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rxrb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_data  (req.data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_res   (out_res)
    );

    // free when empty or being taken this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
endmodule

### verif/rx_ring_buffer_line_reader_test.sv
// ---------------------------------------------------------------------------
// rx_ring_buffer_line_reader_test
// Self-checking bench for the receive ring buffer line reader. Requests go
// in on the req channel, and a local copy of the ring computes the results
// that each accepted request must produce. A checker compares every result
// transaction on rsp, in order, against that prediction. Stimulus is a
// directed pass, an overrun pass, a long receiver hold-off, and random
// traffic under several idling mixes.
// ---------------------------------------------------------------------------
module rx_ring_buffer_line_reader_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rxrb_pkg::*;

    // cycles to let pass after the last expected result; covers a full
    // scan of the ring plus the output pipeline
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_PRINTED   = 50;

    logic clk;
    logic rst_n;

    rxrb_stream_if #(.payload_t(request_t)) req_ch ();
    rxrb_stream_if #(.payload_t(result_t))  rsp_ch ();

    rx_ring_buffer_line_reader dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // local copy of the ring and its pointers; 6-bit pointers wrap by width
    logic [7:0] ring_copy [64];
    logic [5:0] wr_ptr_copy;
    logic [5:0] rd_ptr_copy;

    // results predicted but not yet seen on rsp, oldest first
    result_t awaited_results [$];

    int error_count;
    int n_requests;
    int n_results;
    int n_by_mode   [4];
    int n_by_status [4];

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;
    // long receiver hold-off, counted down by the receiver process
    int hold_left;

    // -----------------------------------------------------------------------
    // Clock
    // -----------------------------------------------------------------------
    always #10 clk = ~clk;

    // -----------------------------------------------------------------------
    // Mismatch reporting: one line each, printing capped, always counted
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------
    function automatic logic [5:0] pending_bytes();
        logic [5:0] d;
        d = wr_ptr_copy - rd_ptr_copy;
        return d;
    endfunction

    function automatic result_t make_result(input logic [7:0] data, input logic has,
                                            input logic last, input logic [1:0] st,
                                            input logic [5:0] avail,
                                            input logic [5:0] cnt);
        result_t r;
        r.data_byte  = data;
        r.has_data   = has;
        r.last       = last;
        r.status     = st;
        r.available  = avail;
        r.read_count = cnt;
        return r;
    endfunction

    function automatic void queue_status(input logic [1:0] st, input logic [5:0] avail);
        awaited_results.push_back(make_result(8'h00, 1'b0, 1'b1, st, avail, 6'd0));
        n_by_status[st]++;
    endfunction

    // n bytes from the read pointer, one result each, last on the final one
    function automatic void queue_bytes(input int n, input logic [5:0] avail);
        logic [5:0] idx;
        for (int i = 0; i < n; i++)
        begin
            idx = rd_ptr_copy + i[5:0];
            awaited_results.push_back(make_result(ring_copy[idx], 1'b1, (i == n - 1),
                                                  ST_OK, avail, n[5:0]));
        end
        n_by_status[ST_OK] += n;
    endfunction

    // Updates the ring copy for one accepted request and queues its results.
    function automatic void apply_request(input request_t r);
        logic [5:0] pend;
        logic [5:0] idx;
        int         pos;
        bit         found;
        pend = wr_ptr_copy - rd_ptr_copy;
        n_by_mode[r.mode]++;
        case (r.mode)
            MODE_PUSH:
            begin
                // no overrun check: a full wrap makes the ring read as empty
                ring_copy[wr_ptr_copy] = r.rx_byte;
                wr_ptr_copy = wr_ptr_copy + 6'd1;
            end
            MODE_QUERY:
                queue_status(ST_OK, pend);
            default:
            begin
                if (pend == 6'd0)
                    queue_status(ST_EMPTY, pend);
                else if (r.mode == MODE_DRAIN)
                begin
                    if (pend > r.max_length)
                        queue_status(ST_TOO_LONG, pend);
                    else
                    begin
                        queue_bytes(int'(pend), pend);
                        rd_ptr_copy = wr_ptr_copy;
                    end
                end
                else
                begin
                    found = 1'b0;
                    pos   = 0;
                    while (!found && pos < pend)
                    begin
                        idx = rd_ptr_copy + pos[5:0];
                        if (ring_copy[idx] == r.delimiter)
                            found = 1'b1;
                        else
                            pos++;
                    end
                    if (!found)
                        queue_status(ST_NOT_FOUND, pend);
                    else if (pos == 0)
                    begin
                        // delimiter first: consumed, checked ahead of length
                        rd_ptr_copy = rd_ptr_copy + 6'd1;
                        queue_status(ST_OK, pend);
                    end
                    else if (pos > r.max_length)
                        queue_status(ST_TOO_LONG, pend);
                    else
                    begin
                        queue_bytes(pos, pend);
                        rd_ptr_copy = rd_ptr_copy + pos[5:0] + 6'd1;
                    end
                end
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Request side. Called at a falling edge, returns at a falling edge with
    // valid still high, so back-to-back transactions never drop valid.
    // -----------------------------------------------------------------------
    task automatic send_request(input request_t r);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= request_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_request(r);
        n_requests++;
        @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        request_t r;
        r            = request_t'($urandom);   // unused fields random
        r.mode       = MODE_PUSH;
        r.rx_byte    = b;
        send_request(r);
    endtask

    task automatic issue_read(input logic [1:0] mode, input logic [6:0] maxlen,
                              input logic [7:0] delim);
        request_t r;
        r            = request_t'($urandom);
        r.mode       = mode;
        r.max_length = maxlen;
        r.delimiter  = delim;
        send_request(r);
    endtask

    task automatic push_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // drop valid after a burst, then hold until every result is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Response side: ready drops at random, or for a long counted hold-off
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            n_results++;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected result data=%h has=%b last=%b st=%0d",
                                          got.data_byte, got.has_data, got.last,
                                          got.status));
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "data %h/%h has %b/%b last %b/%b st %0d/%0d avail %0d/%0d cnt %0d/%0d",
                        got.data_byte, want.data_byte, got.has_data, want.has_data,
                        got.last, want.last, got.status, want.status,
                        got.available, want.available, got.read_count, want.read_count));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // every mode and each corner case once, in a known order
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        issue_read(MODE_QUERY, 7'd0, 8'h00);      // nothing pending
        issue_read(MODE_DRAIN, 7'd127, 8'hFF);    // drain on empty
        issue_read(MODE_LINE, 7'd0, 8'h00);       // line on empty
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
        issue_read(MODE_QUERY, 7'd127, 8'hFF);
        issue_read(MODE_DRAIN, 7'd2, 8'h00);      // one short of the count
        issue_read(MODE_DRAIN, 7'd3, 8'h00);      // exactly the count
        push_byte(8'h0A);
        push_byte(8'h78);
        issue_read(MODE_LINE, 7'd0, 8'h0A);       // delimiter first, max 0
        issue_read(MODE_LINE, 7'd64, 8'h0A);      // no delimiter pending
        push_byte(8'h79);
        push_byte(8'h0A);
        issue_read(MODE_LINE, 7'd1, 8'h0A);       // line too long
        issue_read(MODE_LINE, 7'd2, 8'h0A);       // line fits exactly
        push_byte(8'hFF);
        issue_read(MODE_DRAIN, 7'd0, 8'h00);      // zero limit
        issue_read(MODE_DRAIN, 7'd127, 8'h00);
        drain_results();
    endtask

    // fullest ring, longest drain, then a full wrap that empties the ring
    task automatic test_overrun();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_random_bytes(63);
        issue_read(MODE_QUERY, 7'd0, 8'h00);
        issue_read(MODE_DRAIN, 7'd63, 8'h00);
        push_random_bytes(64);
        issue_read(MODE_QUERY, 7'd0, 8'h00);
        issue_read(MODE_LINE, 7'd127, 8'h00);
        drain_results();
    endtask

    // receiver blocks for a long stretch while requests keep coming, so the
    // output register fills and the block stops taking requests
    task automatic test_receiver_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        push_random_bytes(12);
        issue_read(MODE_DRAIN, 7'd127, 8'h00);
        issue_read(MODE_QUERY, 7'd0, 8'h00);
        push_byte(8'h31);
        push_byte(8'h32);
        push_byte(8'h0D);
        issue_read(MODE_LINE, 7'd64, 8'h0D);
        issue_read(MODE_LINE, 7'd64, 8'h0D);
        drain_results();
    endtask

    // Mostly well-formed lines (bytes, delimiter, line read) with limits
    // around the line length; drains, queries, random pushes and noise fill the rest.
    task automatic run_random_traffic(input int n_items, input int idle, input int stall);
        int         start;
        int         choice;
        int         len;
        int         target;
        int         maxlen;
        logic [7:0] delim;
        logic [7:0] b;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        start          = n_requests;
        while (n_requests - start < n_items)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 55)
            begin
                if (pending_bytes() > 40)
                    issue_read(MODE_DRAIN, 7'd127, 8'($urandom_range(0, 255)));
                delim = 8'($urandom_range(0, 255));
                len   = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 30)
                                                     : $urandom_range(0, 10);
                for (int i = 0; i < len; i++)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == delim);
                    push_byte(b);
                end
                // a few lines are left unterminated
                if ($urandom_range(0, 9) != 0)
                    push_byte(delim);
                target = int'(pending_bytes());
                case ($urandom_range(0, 3))
                    0:       maxlen = $urandom_range(0, 127);
                    1:       maxlen = target - 1;
                    2:       maxlen = target - 2;
                    default: maxlen = 64;
                endcase
                if (maxlen < 0)
                    maxlen = 0;
                if ($urandom_range(0, 9) == 0)
                    delim = 8'($urandom_range(0, 255));
                issue_read(MODE_LINE, maxlen[6:0], delim);
            end
            else if (choice < 72)
            begin
                target = int'(pending_bytes());
                case ($urandom_range(0, 2))
                    0:       maxlen = $urandom_range(0, 127);
                    1:       maxlen = target;
                    default: maxlen = (target > 0) ? target - 1 : 0;
                endcase
                issue_read(MODE_DRAIN, maxlen[6:0], 8'($urandom_range(0, 255)));
            end
            else if (choice < 80)
                issue_read(MODE_QUERY, 7'($urandom_range(0, 127)),
                           8'($urandom_range(0, 255)));
            else if (choice < 90)
                push_random_bytes($urandom_range(1, 6));
            else
                send_request(request_t'($urandom));
        end
        drain_results();
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        wr_ptr_copy    = '0;
        rd_ptr_copy    = '0;
        error_count    = 0;
        n_requests     = 0;
        n_results      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        for (int i = 0; i < 4; i++)
        begin
            n_by_mode[i]   = 0;
            n_by_status[i] = 0;
        end
        for (int i = 0; i < 64; i++)
            ring_copy[i] = 8'h00;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_overrun();
        test_receiver_holdoff();
        run_random_traffic(45, 0, 0);
        run_random_traffic(45, 65, 0);
        run_random_traffic(45, 0, 65);
        run_random_traffic(45, 38, 38);

        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

        $display("Covered %0d requests (push %0d, query %0d, drain %0d, line %0d), %0d results.",
                 n_requests, n_by_mode[MODE_PUSH], n_by_mode[MODE_QUERY],
                 n_by_mode[MODE_DRAIN], n_by_mode[MODE_LINE], n_results);
        $display("Statuses ok %0d, empty %0d, too_long %0d, not_found %0d; %0d mismatches.",
                 n_by_status[ST_OK], n_by_status[ST_EMPTY], n_by_status[ST_TOO_LONG],
                 n_by_status[ST_NOT_FOUND], error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/rxrb_pkg.sv
rtl/rxrb_stream_if.sv
rtl/rxrb_ring_mem.sv
rtl/rxrb_ctrl.sv
rtl/rx_ring_buffer_line_reader.sv
verif/rx_ring_buffer_line_reader_test.sv
